FILE: src/clsc_pkg.sv
// ----------------------------------------------------------------------------
// clsc_pkg
// Shared types, constants and helpers of the cable length step correction.
// ----------------------------------------------------------------------------
package clsc_pkg;

  localparam int NUM_LANES     = 8;
  localparam int LANE_W        = 3;
  localparam int DATA_W        = 32;
  localparam int SCALE_W       = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_W          = (NUM_LANES + 2) * DATA_W;
  localparam int OUT_W         = NUM_LANES * DATA_W;
  localparam int MOTORS_DEFAULT = 8;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_SCALE = 3'd0,
    REG_SCALE_01   = 3'd1,
    REG_SCALE_23   = 3'd2,
    REG_SCALE_45   = 3'd3,
    REG_SCALE_67   = 3'd4
  } cfg_reg_e;

  localparam logic [SCALE_W-1:0]    AXIS_SCALE_RST  = 16'h1000;
  localparam logic [CFG_DATA_W-1:0] MOTOR_SCALE_RST = 32'h1000_1000;

  // geometry in Q16.16 mm
  localparam logic signed [31:0] Q_Z1  = 32'sd11019878;
  localparam logic signed [31:0] Q_Z2  = 32'sd16092365;
  localparam logic signed [31:0] Q_K40 = 32'sd2621440;
  localparam logic [63:0]        Q_A   = 64'd301466;
  localparam logic [63:0]        A_SQ  = Q_A * Q_A;

  // square root unit: 32 result bits
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = SQ_ROOT_W / SQ_STEPS;

  // divider: 32-bit dividend, 20-bit divisor
  localparam int DV_NUM_W  = 32;
  localparam int DV_DEN_W  = SCALE_W + 4;
  localparam int DV_STEPS  = 2;
  localparam int DV_STAGES = DV_NUM_W / DV_STEPS;

  typedef struct packed {
    logic                      last;
    logic [LANE_W-1:0]         idx;
    logic signed [DATA_W-1:0]  steps;
    logic [SCALE_W-1:0]        scale;
    logic                      neg;
  } clsc_tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return 32'(v);
    end
  endfunction

  // x^2 + y^2 of each motor anchor offset
  function automatic logic [63:0] geo_k(input logic [LANE_W-1:0] m);
    case (m)
      3'd0:    return 64'd625213 * 64'd625213 + 64'd3605135 * 64'd3605135;
      3'd1:    return 64'd448266 * 64'd448266 + 64'd2191524 * 64'd2191524;
      3'd2:    return 64'd625213 * 64'd625213 + 64'd1830420 * 64'd1830420;
      3'd3:    return 64'd1038090 * 64'd1038090 + 64'd3311534 * 64'd3311534;
      3'd4:    return 64'd1042022 * 64'd1042022 + 64'd3432776 * 64'd3432776;
      3'd5:    return 64'd625213 * 64'd625213 + 64'd1777992 * 64'd1777992;
      3'd6:    return 64'd1042022 * 64'd1042022 + 64'd2247885 * 64'd2247885;
      default: return 64'd625213 * 64'd625213 + 64'd4100588 * 64'd4100588;
    endcase
  endfunction

endpackage

FILE: src/clsc_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// clsc_sqrt_pipe
// Pipelined floor square root of 64-bit radicands, several lanes side by side.
// ----------------------------------------------------------------------------
module clsc_sqrt_pipe #(
  parameter int LANES = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  clsc_pkg::clsc_tag_t                          tag_i,
  input  logic [LANES-1:0][2*clsc_pkg::SQ_ROOT_W-1:0]  rad_i,
  output logic                                         valid_o,
  output clsc_pkg::clsc_tag_t                          tag_o,
  output logic [LANES-1:0][clsc_pkg::SQ_ROOT_W-1:0]    root_o
);
  import clsc_pkg::*;

  localparam int RW   = SQ_ROOT_W;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;

  logic                        v_q    [SQ_STAGES];
  clsc_tag_t                   tag_q  [SQ_STAGES];
  logic [LANES-1:0][RADW-1:0]  rad_q  [SQ_STAGES];
  logic [LANES-1:0][REMW-1:0]  rem_q  [SQ_STAGES];
  logic [LANES-1:0][RW-1:0]    root_q [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic                        src_v;
    clsc_tag_t                   src_tag;
    logic [LANES-1:0][RADW-1:0]  src_rad;
    logic [LANES-1:0][REMW-1:0]  src_rem;
    logic [LANES-1:0][RW-1:0]    src_root;
    logic [LANES-1:0][RADW-1:0]  rad_d;
    logic [LANES-1:0][REMW-1:0]  rem_d;
    logic [LANES-1:0][RW-1:0]    root_d;
    logic [REMW+1:0]             r2;
    logic [REMW+1:0]             trial;

    if (s == 0) begin : g_first
      assign src_v    = valid_i;
      assign src_tag  = tag_i;
      assign src_rad  = rad_i;
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_next
      assign src_v    = v_q[s-1];
      assign src_tag  = tag_q[s-1];
      assign src_rad  = rad_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_root = root_q[s-1];
    end

    always_comb begin
      rad_d  = src_rad;
      rem_d  = src_rem;
      root_d = src_root;
      r2    = '0;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < SQ_STEPS; k++) begin
          r2    = {rem_d[l], rad_d[l][RADW-1 -: 2]};
          trial = {2'b00, root_d[l], 2'b01};
          if (r2 >= trial) begin
            rem_d[l]  = REMW'(r2 - trial);
            root_d[l] = {root_d[l][RW-2:0], 1'b1};
          end else begin
            rem_d[l]  = REMW'(r2);
            root_d[l] = {root_d[l][RW-2:0], 1'b0};
          end
          rad_d[l] = {rad_d[l][RADW-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s]  <= src_tag;
        rad_q[s]  <= rad_d;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign tag_o   = tag_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1];

endmodule

FILE: src/clsc_div_pipe.sv
// ----------------------------------------------------------------------------
// clsc_div_pipe
// Pipelined restoring unsigned divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module clsc_div_pipe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  clsc_pkg::clsc_tag_t             tag_i,
  input  logic [clsc_pkg::DV_NUM_W-1:0]   num_i,
  input  logic [clsc_pkg::DV_DEN_W-1:0]   den_i,
  output logic                            valid_o,
  output clsc_pkg::clsc_tag_t             tag_o,
  output logic [clsc_pkg::DV_NUM_W-1:0]   quot_o
);
  import clsc_pkg::*;

  logic                 v_q    [DV_STAGES];
  clsc_tag_t            tag_q  [DV_STAGES];
  logic [DV_NUM_W-1:0]  num_q  [DV_STAGES];
  logic [DV_DEN_W-1:0]  den_q  [DV_STAGES];
  logic [DV_DEN_W-1:0]  rem_q  [DV_STAGES];
  logic [DV_NUM_W-1:0]  quot_q [DV_STAGES];

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
    logic                 src_v;
    clsc_tag_t            src_tag;
    logic [DV_DEN_W-1:0]  src_den;
    logic [DV_NUM_W-1:0]  src_num;
    logic [DV_DEN_W-1:0]  src_rem;
    logic [DV_NUM_W-1:0]  src_quot;
    logic [DV_NUM_W-1:0]  num_d;
    logic [DV_DEN_W-1:0]  rem_d;
    logic [DV_NUM_W-1:0]  quot_d;
    logic [DV_DEN_W:0]    r2;

    if (s == 0) begin : g_first
      assign src_v    = valid_i;
      assign src_tag  = tag_i;
      assign src_den  = den_i;
      assign src_num  = num_i;
      assign src_rem  = '0;
      assign src_quot = '0;
    end else begin : g_next
      assign src_v    = v_q[s-1];
      assign src_tag  = tag_q[s-1];
      assign src_den  = den_q[s-1];
      assign src_num  = num_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_quot = quot_q[s-1];
    end

    always_comb begin
      num_d  = src_num;
      rem_d  = src_rem;
      quot_d = src_quot;
      r2 = '0;
      for (int k = 0; k < DV_STEPS; k++) begin
        r2 = {rem_d, num_d[DV_NUM_W-1]};
        if (r2 >= {1'b0, src_den}) begin
          rem_d  = DV_DEN_W'(r2 - {1'b0, src_den});
          quot_d = {quot_d[DV_NUM_W-2:0], 1'b1};
        end else begin
          rem_d  = r2[DV_DEN_W-1:0];
          quot_d = {quot_d[DV_NUM_W-2:0], 1'b0};
        end
        num_d = {num_d[DV_NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s]  <= src_tag;
        den_q[s]  <= src_den;
        num_q[s]  <= num_d;
        rem_q[s]  <= rem_d;
        quot_q[s] <= quot_d;
      end
    end
  end

  assign valid_o = v_q[DV_STAGES-1];
  assign tag_o   = tag_q[DV_STAGES-1];
  assign quot_o  = quot_q[DV_STAGES-1];

endmodule

FILE: src/cable_length_step_correction_unit.sv
// ----------------------------------------------------------------------------
// cable_length_step_correction_unit
// Adds the rounded cable length change of each motor to its step count.
// ----------------------------------------------------------------------------
//  port group   dir  word
//  s_axis_*     in   8 motor step counts, axis steps, axis position
//  m_axis_*     out  8 corrected counts; tuser = saturated
//  cfg_*        in   register write: axis scale, packed motor scales
//
//  The eight motors of a move word share one pipeline and enter it one per
//  cycle while the output is not stalled; a new word is taken as its last motor enters.
//  A motor spends 5 + 16 (root) + 3 + 16 (divide) stages in the pipeline;
//  the result word is loaded into the output register as its last motor leaves the divider.
//  A stalled output register freezes the whole pipeline; nothing is lost.
//  Reset clears valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module cable_length_step_correction_unit #(
  parameter int MOTORS = clsc_pkg::MOTORS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // steps_motor_0..7, axis_steps, axis_position (32 bits each)
  input  logic [clsc_pkg::IN_W-1:0]         s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // corrected_0..7 (32 bits each)
  output logic [clsc_pkg::OUT_W-1:0]        m_axis_tdata,
  // saturated
  output logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [clsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [clsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import clsc_pkg::*;

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);

  // configuration
  logic [SCALE_W-1:0]                    axis_scale_q;
  logic [NUM_LANES/2-1:0][CFG_DATA_W-1:0] mscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_scale_q <= AXIS_SCALE_RST;
      mscale_q     <= {(NUM_LANES/2){MOTOR_SCALE_RST}};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_AXIS_SCALE: axis_scale_q <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_01:   mscale_q[0]  <= cfg_data_i;
        REG_SCALE_23:   mscale_q[1]  <= cfg_data_i;
        REG_SCALE_45:   mscale_q[2]  <= cfg_data_i;
        REG_SCALE_67:   mscale_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // issue: one motor per cycle while the pipeline is not stalled
  logic                en;
  logic                busy_q;
  logic [LANE_W-1:0]   cnt_q;
  logic [IN_W-1:0]     item_q;
  logic                last_issue;
  logic                accept;
  logic                m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign last_issue    = busy_q && (cnt_q == LAST_LANE);
  assign s_axis_tready = en && (!busy_q || last_issue);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (en && busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last_issue) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= s_axis_tdata;
    end
  end

  logic signed [DATA_W-1:0] pos;
  logic signed [DATA_W-1:0] mv;
  logic [SCALE_W-1:0]       scale_sel;
  clsc_tag_t                tag0;

  assign mv  = item_q[NUM_LANES*DATA_W +: DATA_W];
  assign pos = item_q[(NUM_LANES+1)*DATA_W +: DATA_W];

  always_comb begin
    scale_sel = cnt_q[0] ? mscale_q[cnt_q[LANE_W-1:1]][2*SCALE_W-1:SCALE_W]
                         : mscale_q[cnt_q[LANE_W-1:1]][SCALE_W-1:0];
    // motors beyond the configured count get no correction
    if (int'(cnt_q) >= MOTORS) begin
      scale_sel = '0;
    end
    tag0.last  = last_issue;
    tag0.idx   = cnt_q;
    tag0.steps = item_q[DATA_W*cnt_q +: DATA_W];
    tag0.scale = scale_sel;
    tag0.neg   = 1'b0;
  end

  // stage 1: axis offsets
  logic                v1_q;
  clsc_tag_t           tag1_q;
  logic signed [48:0]  pp1_q;
  logic signed [48:0]  dp1_q;

  // stage 2: current and new offset
  logic                     v2_q;
  clsc_tag_t                tag2_q;
  logic signed [DATA_W-1:0] p2_q;
  logic signed [DATA_W-1:0] qn2_q;
  logic signed [DATA_W-1:0] p_d;
  logic signed [DATA_W-1:0] d_d;

  // stage 3: triangle legs
  logic                     v3_q;
  clsc_tag_t                tag3_q;
  logic signed [DATA_W-1:0] uc3_q, vc3_q, un3_q, vn3_q;
  logic signed [DATA_W-1:0] z_sel;

  // stage 4: squares
  logic                v4_q;
  clsc_tag_t           tag4_q;
  logic [63:0]         usc4_q, vsc4_q, usn4_q, vsn4_q;

  // stage 5: radicands
  logic                v5_q;
  clsc_tag_t           tag5_q;
  logic [3:0][63:0]    rad5_q;

  assign p_d   = sat32(64'(pp1_q) <<< 4);
  assign d_d   = sat32(64'(dp1_q) <<< 4);
  assign z_sel = tag2_q.idx[0] ? Q_Z2 : Q_Z1;

  function automatic logic [63:0] sq(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? -33'(v) : 33'(v);
    return 64'(m[31:0]) * 64'(m[31:0]);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= busy_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag1_q <= tag0;
      pp1_q  <= pos * $signed({1'b0, axis_scale_q});
      dp1_q  <= mv * $signed({1'b0, axis_scale_q});

      tag2_q <= tag1_q;
      p2_q   <= p_d;
      qn2_q  <= sat32(64'(p_d) + 64'(d_d));

      tag3_q <= tag2_q;
      uc3_q  <= sat32(64'(Q_K40) + 64'(p2_q));
      vc3_q  <= sat32(64'(z_sel) - 64'(p2_q));
      un3_q  <= sat32(64'(Q_K40) + 64'(qn2_q));
      vn3_q  <= sat32(64'(z_sel) - 64'(qn2_q));

      tag4_q <= tag3_q;
      usc4_q <= sq(uc3_q);
      vsc4_q <= sq(vc3_q);
      usn4_q <= sq(un3_q);
      vsn4_q <= sq(vn3_q);

      tag5_q    <= tag4_q;
      rad5_q[0] <= A_SQ + usc4_q;
      rad5_q[1] <= vsc4_q + geo_k(tag4_q.idx);
      rad5_q[2] <= A_SQ + usn4_q;
      rad5_q[3] <= vsn4_q + geo_k(tag4_q.idx);
    end
  end

  logic                         sq_v;
  clsc_tag_t                    sq_tag;
  logic [3:0][SQ_ROOT_W-1:0]    sq_root;

  clsc_sqrt_pipe #(
    .LANES (4)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .tag_i   (tag5_q),
    .rad_i   (rad5_q),
    .valid_o (sq_v),
    .tag_o   (sq_tag),
    .root_o  (sq_root)
  );

  function automatic logic signed [31:0] cable_len(input logic [31:0] r0, input logic [31:0] r1);
    logic [63:0] a;
    logic [63:0] b;
    a = {32'd0, r0[31] ? 32'h7FFF_FFFF : r0};
    b = {32'd0, r1[31] ? 32'h7FFF_FFFF : r1};
    return sat32(64'd0 - (a + b));
  endfunction

  // stage 6: lengths, stage 7: difference, stage 8: rounded dividend
  logic                     v6_q, v7_q, v8_q;
  clsc_tag_t                tag6_q, tag7_q, tag8_q;
  logic signed [DATA_W-1:0] lc6_q, ln6_q;
  logic signed [DATA_W-1:0] diff7_q;
  logic [DV_NUM_W-1:0]      num8_q;
  logic [32:0]              mag7;
  clsc_tag_t                tag7_d;

  assign mag7 = diff7_q[DATA_W-1] ? -33'(diff7_q) : 33'(diff7_q);

  always_comb begin
    tag7_d     = tag7_q;
    tag7_d.neg = diff7_q[DATA_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v6_q <= sq_v;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag6_q  <= sq_tag;
      lc6_q   <= cable_len(sq_root[0], sq_root[1]);
      ln6_q   <= cable_len(sq_root[2], sq_root[3]);
      tag7_q  <= tag6_q;
      diff7_q <= sat32(64'(ln6_q) - 64'(lc6_q));
      tag8_q  <= tag7_d;
      // add half the divisor to round to nearest
      num8_q  <= mag7[DV_NUM_W-1:0] + {{(DV_NUM_W-SCALE_W-3){1'b0}}, tag7_q.scale, 3'b000};
    end
  end

  logic                 dv_v;
  clsc_tag_t            dv_tag;
  logic [DV_NUM_W-1:0]  dv_quot;

  clsc_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .tag_i   (tag8_q),
    .num_i   (num8_q),
    .den_i   ({tag8_q.scale, 4'b0000}),
    .valid_o (dv_v),
    .tag_o   (dv_tag),
    .quot_o  (dv_quot)
  );

  // apply correction and gather the lanes of one word
  logic signed [63:0]                  corr;
  logic signed [63:0]                  total;
  logic signed [DATA_W-1:0]            total_sat;
  logic                                clip;
  logic [NUM_LANES-1:0][DATA_W-1:0]    lanes_q;
  logic [NUM_LANES-1:0][DATA_W-1:0]    lanes_d;
  logic                                clip_acc_q;
  logic [OUT_W-1:0]                    m_data_q;
  logic                                m_user_q;

  always_comb begin
    if (dv_tag.scale == '0) begin
      corr = '0;
    end else if (dv_tag.neg) begin
      corr = 64'sd0 - $signed({32'd0, dv_quot});
    end else begin
      corr = $signed({32'd0, dv_quot});
    end
    total     = 64'(dv_tag.steps) + corr;
    total_sat = sat32(total);
    clip      = (64'(total_sat) != total);
    lanes_d             = lanes_q;
    lanes_d[dv_tag.idx] = total_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      clip_acc_q <= 1'b0;
    end else begin
      if (en && dv_v && dv_tag.last) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (en && dv_v) begin
        clip_acc_q <= dv_tag.last ? 1'b0 : (clip_acc_q | clip);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && dv_v) begin
      lanes_q <= lanes_d;
      if (dv_tag.last) begin
        m_data_q <= lanes_d;
        m_user_q <= clip_acc_q | clip;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // checks
  a_last_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v && dv_tag.last |-> dv_tag.idx == LAST_LANE)
    else $error("word closed on a lane other than the last");

  a_zero_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v && dv_tag.scale == '0 |-> total_sat == dv_tag.steps && !clip)
    else $error("zero scale changed the step count");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(cnt_q) && $stable(busy_q))
    else $error("issue advanced during a stall");

endmodule

FILE: tb/tb_cable_length_step_correction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cable_length_step_correction_unit
// Writes the scale registers, drives move words with random gaps and output
// stalls, predicts each corrected word in fixed point and compares its counts and saturation flag.
// ----------------------------------------------------------------------------
module tb_cable_length_step_correction_unit;
  import clsc_pkg::*;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] mv;
    logic [7:0][31:0]   steps;
  } move_t;

  typedef struct packed {
    logic             sat;
    logic [7:0][31:0] cnt;
  } corr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  cable_length_step_correction_unit dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] axis_scale_q;
  logic [3:0][31:0] motor_scale_q;
  move_t pending_moves[$];
  corr_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit stall_long = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint isqrt(logic [63:0] n);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic logic [63:0] sq(longint v);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    return m * m;
  endfunction

  function automatic longint cable_len(int m, longint q);
    longint ax[8] = '{625213, 448266, 625213, 1038090, 1042022, 625213, 1042022, 625213};
    longint ay[8] = '{3605135, 2191524, 1830420, 3311534, 3432776, 1777992, 2247885,
                      4100588};
    longint z, u, v, s1, s2;
    z = (m & 1) ? 64'sd16092365 : 64'sd11019878;
    u = clip32(64'sd2621440 + q);
    v = clip32(z - q);
    s1 = clip32(isqrt(sq(301466) + sq(u)));
    s2 = clip32(isqrt(sq(v) + sq(ax[m]) + sq(ay[m])));
    return clip32(-(s1 + s2));
  endfunction

  function automatic corr_t correct_move(move_t mw);
    corr_t r;
    longint p, d, qn, diff, tot, corr;
    logic [63:0] mag, den;
    logic [15:0] sc;
    p = clip32(longint'(mw.pos) * longint'(axis_scale_q) * 16);
    d = clip32(longint'(mw.mv) * longint'(axis_scale_q) * 16);
    qn = clip32(p + d);
    r.sat = 1'b0;
    for (int i = 0; i < 8; i++) begin
      sc = motor_scale_q[i >> 1][(i & 1) * 16 +: 16];
      corr = 0;
      if (sc != 0) begin
        diff = clip32(cable_len(i, qn) - cable_len(i, p));
        mag = diff < 0 ? -diff : diff;
        den = 64'(sc) * 16;
        corr = longint'((mag + den / 2) / den);
        if (diff < 0) corr = -corr;
      end
      tot = longint'(signed'(mw.steps[i])) + corr;
      if (tot != clip32(tot)) r.sat = 1'b1;
      r.cnt[i] = 32'(clip32(tot));
    end
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
           ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(correct_move(pending_moves.pop_front()));
        tx_gap <= pick_gap();
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (pending_moves.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {pending_moves[0].pos, pending_moves[0].mv, pending_moves[0].steps};
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    corr_t want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
        end else begin
          want = expected_words.pop_front();
          if (want.cnt != m_axis_tdata || want.sat != m_axis_tuser) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %h/%b got %h/%b", want.cnt, want.sat,
                       m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (stall_long) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_gap <= pick_gap();
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    if (cycles > 600000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_move(logic signed [31:0] pos, logic signed [31:0] mv,
                          logic [7:0][31:0] st);
    move_t mw;
    mw.pos = pos;
    mw.mv = mv;
    mw.steps = st;
    pending_moves.push_back(mw);
  endtask

  function automatic logic [31:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 400)) - 200);
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == REG_AXIS_SCALE) axis_scale_q = val[15:0];
    else motor_scale_q[idx - 1] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_moves.size() > 0 || expected_words.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_moves(int n);
    logic [7:0][31:0] st;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 8; i++) st[i] = rnd_field();
      // mostly realistic axis travel, sometimes full range
      if ($urandom_range(0, 3) == 0)
        add_move(rnd_field(), rnd_field(), st);
      else
        add_move(32'(signed'($urandom_range(0, 20000)) - 10000),
                 32'(signed'($urandom_range(0, 20000)) - 10000), st);
    end
  endtask

  initial begin
    logic [7:0][31:0] st;
    axis_scale_q = AXIS_SCALE_RST;
    motor_scale_q = {4{MOTOR_SCALE_RST}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero move, saturation both ways
    st = '0;
    add_move(0, 0, st);
    add_move(0, 100, st);
    add_move(100, -100, st);
    add_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, {8{32'h7FFF_FFFF}});
    add_move(32'h8000_0000, 32'h8000_0000, {8{32'h8000_0000}});
    add_move(32'h8000_0000, 32'h7FFF_FFFF, {8{32'h7FFF_FFFF}});
    add_move(32'h7FFF_FFFF, 32'h8000_0000, {8{32'h8000_0000}});
    add_move(-500, 1000, {8{32'hFFFF_FFFF}});
    add_move(32'hAAAA_AAAA, 32'h5555_5555, {8{32'h5555_5555}});
    add_move(32'h5555_5555, 32'hAAAA_AAAA, {8{32'hAAAA_AAAA}});
    drain();

    // zero scales pass counts through; minimum and maximum scales
    write_reg(REG_AXIS_SCALE, 32'hFFFF);
    write_reg(REG_SCALE_01, 32'h0000_0001);
    write_reg(REG_SCALE_23, 32'hFFFF_0000);
    write_reg(REG_SCALE_45, 32'h0000_0000);
    write_reg(REG_SCALE_67, 32'h0001_FFFF);
    add_move(0, 50, st);
    add_move(-3000, 6000, {8{32'h7FFF_FFF0}});
    add_move(3000, -6000, {8{32'h8000_0010}});
    add_move(32'h8000_0000, 32'h7FFF_FFFF, st);
    random_moves(100);
    drain();

    write_reg(REG_AXIS_SCALE, 32'h0000);
    random_moves(40);
    drain();

    // receiver holds off long enough to back up the pipeline
    write_reg(REG_AXIS_SCALE, 32'h0040);
    write_reg(REG_SCALE_01, $urandom());
    write_reg(REG_SCALE_23, $urandom());
    write_reg(REG_SCALE_45, $urandom());
    write_reg(REG_SCALE_67, $urandom());
    stall_long = 1'b1;
    random_moves(150);
    repeat (800) @(posedge clk_i);
    stall_long = 1'b0;
    drain();

    write_reg(REG_AXIS_SCALE, 32'h1000);
    write_reg(REG_SCALE_01, 32'h1000_0800);
    write_reg(REG_SCALE_23, 32'h0200_2000);
    write_reg(REG_SCALE_45, 32'h0100_0010);
    write_reg(REG_SCALE_67, 32'h4000_8000);
    random_moves(150);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: cable_length_step_correction_unit.f
src/clsc_pkg.sv
src/clsc_sqrt_pipe.sv
src/clsc_div_pipe.sv
src/cable_length_step_correction_unit.sv
tb/tb_cable_length_step_correction_unit.sv
